[rtl/eapr_pkg.sv]
// Package for the elementary automaton pixel recolor block.
// Holds payload structs, cell control struct, register indexes and widths.
// No dependencies.
package eapr_pkg;

    localparam int MAX_ROWS_DEF = 64;
    localparam int RULE_BITS = 8;
    localparam int COLOR_W = 24;
    localparam int ALPHA_W = 8;
    localparam int SEED_W = 64;
    localparam int HEIGHT_W = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 7'd64;
    localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] REG_RULE_NUMBER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_ON = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_OFF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_PATTERN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_HEIGHT = 3'd4;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel_color;
        logic [ALPHA_W-1:0] pixel_alpha;
        logic               start_image;
    } in_item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] out_color;
        logic [ALPHA_W-1:0] out_alpha;
        logic               cell_value;
        logic               column_end;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic start;
        logic last;
    } cell_ctrl_t;

endpackage

[rtl/eapr_cell.sv]
// One automaton cell: holds this row's bit of the current and the next ring.
// Depends on eapr_pkg for the control struct and the rule width.
module eapr_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  eapr_pkg::cell_ctrl_t          ctrl,
    input  logic [eapr_pkg::RULE_BITS-1:0] rule,
    input  logic                          seed_bit,
    input  logic                          sel,
    input  logic                          left,
    input  logic                          right,
    output logic                          cur_eff,
    output logic                          cell_new
);

    logic cur_reg;
    logic cur_next;
    logic nxt_reg;
    logic nxt_next;
    logic nxt_base;
    logic nxt_val;

    assign cur_eff = ctrl.start ? seed_bit : cur_reg;
    assign cell_new = rule[{left, cur_eff, right}];
    assign nxt_base = ctrl.start ? 1'b0 : nxt_reg;
    assign nxt_val = sel ? cell_new : nxt_base;

    always_comb
    begin
        cur_next = cur_reg;
        nxt_next = nxt_reg;
        if (ctrl.accept)
        begin
            if (ctrl.last)
            begin
                cur_next = nxt_val;
                nxt_next = 1'b0;
            end
            else
            begin
                cur_next = cur_eff;
                nxt_next = nxt_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= 1'b0;
            nxt_reg <= 1'b0;
        end
        else
        begin
            cur_reg <= cur_next;
            nxt_reg <= nxt_next;
        end
    end

endmodule

[rtl/eapr_out_buf.sv]
// Output register with a skid entry for result items.
// Depends on eapr_pkg for the result item struct.
module eapr_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  eapr_pkg::out_item_t load_item,
    output logic                full,
    output logic                out_valid,
    input  logic                out_stall,
    output eapr_pkg::out_item_t out_item
);

    logic                main_valid_reg;
    logic                main_valid_next;
    logic                skid_valid_reg;
    logic                skid_valid_next;
    eapr_pkg::out_item_t main_item_reg;
    eapr_pkg::out_item_t main_item_next;
    eapr_pkg::out_item_t skid_item_reg;
    eapr_pkg::out_item_t skid_item_next;
    logic                take;

    assign take = main_valid_reg && !out_stall;
    assign full = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_item = main_item_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_item_next = main_item_reg;
        skid_item_next = skid_item_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                main_item_next = skid_item_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (load)
        begin
            if (!main_valid_reg || take)
            begin
                main_item_next = load_item;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_item_next = load_item;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_item_reg <= main_item_next;
        skid_item_reg <= skid_item_next;
    end

endmodule

[rtl/elementary_automaton_pixel_recolor_core.sv]
// Top level of the elementary automaton pixel recolor block.
// Result items are registered in the output buffer. Throughput: one item per cycle
// while input stall is low, set by the row of cells that all update at once.
// Two result items can be held, so input stall rises only when both are full.
// Reset clears the cell ring, row counter and handshake state at once and loads the
// register defaults; there is no clearing pass.
module elementary_automaton_pixel_recolor_core #(
    parameter int MAX_ROWS = eapr_pkg::MAX_ROWS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  eapr_pkg::in_item_t                 in_item,
    output logic                               out_valid,
    input  logic                               out_stall,
    output eapr_pkg::out_item_t                out_item,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [eapr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [eapr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int HW = eapr_pkg::HEIGHT_W;
    localparam logic [HW-1:0] MAX_ROWS_H = HW'(MAX_ROWS);

    logic [eapr_pkg::RULE_BITS-1:0] rule_number_reg;
    logic [eapr_pkg::COLOR_W-1:0]   color_on_reg;
    logic [eapr_pkg::COLOR_W-1:0]   color_off_reg;
    logic [eapr_pkg::SEED_W-1:0]    seed_pattern_reg;
    logic [HW-1:0]                  column_height_reg;

    logic [ROW_W-1:0] row_index_reg;
    logic [ROW_W-1:0] row_index_next;

    logic [HW-1:0]       height;
    logic [ROW_W-1:0]    hm1;
    logic [ROW_W-1:0]    row;
    logic                last;
    logic                accept;
    logic                buf_full;
    logic                row_cell;
    eapr_pkg::cell_ctrl_t ctrl;
    eapr_pkg::out_item_t  result;

    logic [MAX_ROWS-1:0] cur_eff;
    logic [MAX_ROWS-1:0] cell_new;
    logic [MAX_ROWS-1:0] sel;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_number_reg <= '0;
            color_on_reg <= '0;
            color_off_reg <= '0;
            seed_pattern_reg <= '0;
            column_height_reg <= eapr_pkg::HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                eapr_pkg::REG_RULE_NUMBER:
                    rule_number_reg <= cfg_data[eapr_pkg::RULE_BITS-1:0];
                eapr_pkg::REG_COLOR_ON:
                    color_on_reg <= cfg_data[eapr_pkg::COLOR_W-1:0];
                eapr_pkg::REG_COLOR_OFF:
                    color_off_reg <= cfg_data[eapr_pkg::COLOR_W-1:0];
                eapr_pkg::REG_SEED_PATTERN:
                    seed_pattern_reg <= cfg_data[eapr_pkg::SEED_W-1:0];
                eapr_pkg::REG_COLUMN_HEIGHT:
                    column_height_reg <= cfg_data[HW-1:0];
                default:
                    ;
            endcase
        end
    end

    assign accept = in_valid && !in_stall;
    assign in_stall = buf_full;

    always_comb
    begin
        if (column_height_reg == '0)
            height = HW'(1);
        else if (column_height_reg > MAX_ROWS_H)
            height = MAX_ROWS_H;
        else
            height = column_height_reg;
    end

    assign hm1 = ROW_W'(height - HW'(1));

    always_comb
    begin
        logic [ROW_W-1:0] base;
        base = in_item.start_image ? '0 : row_index_reg;
        if ({{(HW-ROW_W){1'b0}}, base} >= height)
            row = hm1;
        else
            row = base;
    end

    assign last = (row == hm1);

    assign ctrl.accept = accept;
    assign ctrl.start = in_item.start_image;
    assign ctrl.last = last;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ROWS; gi++)
        begin : g_cell
            logic left;
            logic right;

            assign sel[gi] = (row == ROW_W'(gi));

            if (gi == 0)
            begin : g_first
                assign left = cur_eff[hm1];
            end
            else
            begin : g_mid
                assign left = cur_eff[gi-1];
            end

            if (gi == MAX_ROWS - 1)
            begin : g_lastc
                assign right = cur_eff[0];
            end
            else
            begin : g_body
                assign right = (hm1 == ROW_W'(gi)) ? cur_eff[0] : cur_eff[gi+1];
            end

            eapr_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .rule     (rule_number_reg),
                .seed_bit (seed_pattern_reg[gi]),
                .sel      (sel[gi]),
                .left     (left),
                .right    (right),
                .cur_eff  (cur_eff[gi]),
                .cell_new (cell_new[gi])
            );
        end
    endgenerate

    assign row_cell = |(cell_new & sel);

    always_comb
    begin
        if (in_item.pixel_alpha != '0)
        begin
            result.out_color = row_cell ? color_on_reg : color_off_reg;
            result.out_alpha = eapr_pkg::ALPHA_OPAQUE;
        end
        else
        begin
            result.out_color = in_item.pixel_color;
            result.out_alpha = in_item.pixel_alpha;
        end
        result.cell_value = row_cell;
        result.column_end = last;
    end

    always_comb
    begin
        row_index_next = row_index_reg;
        if (accept)
            row_index_next = last ? '0 : row + ROW_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_index_reg <= '0;
        else
            row_index_reg <= row_index_next;
    end

    eapr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_item (result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

[rtl/eapr_checker.sv]
// Port-level checker for the elementary automaton pixel recolor block.
// Depends on eapr_pkg and is bound to the top level at the end of this file.
module eapr_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input eapr_pkg::out_item_t             out_item
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("Stalled result item changed or vanished.");

    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.out_alpha != eapr_pkg::ALPHA_OPAQUE |->
            out_item.out_alpha == '0)
        else $error("Result alpha is neither opaque nor transparent.");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("Input stalled while no result item is pending.");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && !in_stall) && !out_valid |=> !out_valid)
        else $error("Result item appeared without an accepted item.");

endmodule

bind elementary_automaton_pixel_recolor_core eapr_checker u_eapr_checker (.*);

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for elementary_automaton_pixel_recolor_core.
// Sends pixel items and register writes, predicts each result item by automaton
// model or a pinned row and compares them. Depends on eapr_pkg and the core RTL.
module tb_top;

    localparam int RANDOM_ITEMS = 1300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS = 10;

    typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t                       kind;
        logic [eapr_pkg::CFG_IDX_W-1:0]  reg_idx;
        logic [eapr_pkg::CFG_DATA_W-1:0] reg_val;
        eapr_pkg::in_item_t              px;
        logic                            pinned;
        eapr_pkg::out_item_t             res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    eapr_pkg::in_item_t in_item;
    logic out_valid;
    logic out_stall;
    eapr_pkg::out_item_t out_item;
    logic cfg_valid;
    logic cfg_ready;
    logic [eapr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [eapr_pkg::CFG_DATA_W-1:0] cfg_data;

    logic pinned_valid;
    eapr_pkg::out_item_t pinned_result;

    logic [eapr_pkg::RULE_BITS-1:0] cur_rule = '0;
    logic [eapr_pkg::COLOR_W-1:0] cur_on = '0;
    logic [eapr_pkg::COLOR_W-1:0] cur_off = '0;
    logic [eapr_pkg::SEED_W-1:0] cur_seed = '0;
    logic [eapr_pkg::HEIGHT_W-1:0] cur_height = eapr_pkg::HEIGHT_RESET;
    logic [eapr_pkg::SEED_W-1:0] ring = '0;
    logic [eapr_pkg::SEED_W-1:0] ring_next = '0;
    logic [5:0] row_ptr = '0;

    eapr_pkg::out_item_t recolored_q[$];
    stim_row_t plan[$];
    int fail_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int random_sent = 0;
    int cycle_count = 0;
    int gap_pct = 6;
    int stall_pct = 65;
    int unsigned img_rows = eapr_pkg::MAX_ROWS_DEF;

    elementary_automaton_pixel_recolor_core i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned rows_for(logic [eapr_pkg::HEIGHT_W-1:0] hv);
        if (hv == 0)
        begin
            return 1;
        end
        if (hv > eapr_pkg::MAX_ROWS_DEF)
        begin
            return eapr_pkg::MAX_ROWS_DEF;
        end
        return 32'(hv);
    endfunction

    function automatic eapr_pkg::out_item_t recolor_pixel(eapr_pkg::in_item_t px);
        int unsigned h;
        int unsigned r;
        logic [2:0] nbhd;
        logic cell_bit;
        eapr_pkg::out_item_t res;
        if (px.start_image)
        begin
            ring = cur_seed;
            ring_next = '0;
            row_ptr = '0;
        end
        h = rows_for(cur_height);
        r = 32'(row_ptr);
        if (r >= h)
        begin
            r = h - 1;
        end
        nbhd = {ring[(r + h - 1) % h], ring[r], ring[(r + 1) % h]};
        cell_bit = cur_rule[nbhd];
        ring_next[r] = cell_bit;
        if (px.pixel_alpha != 0)
        begin
            res.out_color = cell_bit ? cur_on : cur_off;
            res.out_alpha = eapr_pkg::ALPHA_OPAQUE;
        end
        else
        begin
            res.out_color = px.pixel_color;
            res.out_alpha = px.pixel_alpha;
        end
        res.cell_value = cell_bit;
        res.column_end = (r == h - 1);
        if (res.column_end)
        begin
            ring = ring_next;
            ring_next = '0;
            row_ptr = '0;
        end
        else
        begin
            row_ptr = 6'(r + 1);
        end
        return res;
    endfunction

    always @(posedge clk)
    begin : scoreboard
        eapr_pkg::out_item_t want;
        eapr_pkg::out_item_t calc;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    eapr_pkg::REG_RULE_NUMBER:
                        cur_rule = cfg_data[eapr_pkg::RULE_BITS-1:0];
                    eapr_pkg::REG_COLOR_ON:
                        cur_on = cfg_data[eapr_pkg::COLOR_W-1:0];
                    eapr_pkg::REG_COLOR_OFF:
                        cur_off = cfg_data[eapr_pkg::COLOR_W-1:0];
                    eapr_pkg::REG_SEED_PATTERN:
                        cur_seed = cfg_data[eapr_pkg::SEED_W-1:0];
                    eapr_pkg::REG_COLUMN_HEIGHT:
                        cur_height = cfg_data[eapr_pkg::HEIGHT_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                calc = recolor_pixel(in_item);
                recolored_q.insert(recolored_q.size(), pinned_valid ? pinned_result : calc);
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (recolored_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                    begin
                        $display("Unexpected result item: color %h alpha %h cell %b end %b",
                                 out_item.out_color, out_item.out_alpha,
                                 out_item.cell_value, out_item.column_end);
                    end
                end
                else
                begin
                    want = recolored_q.pop_front();
                    if (out_item.out_color !== want.out_color
                        || out_item.out_alpha !== want.out_alpha
                        || out_item.cell_value !== want.cell_value
                        || out_item.column_end !== want.column_end)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                        begin
                            $display("Item %0d: color %h exp %h, alpha %h exp %h, %s",
                                     results_seen, out_item.out_color, want.out_color,
                                     out_item.out_alpha, want.out_alpha,
                                     $sformatf("cell %b exp %b, end %b exp %b",
                                               out_item.cell_value, want.cell_value,
                                               out_item.column_end, want.column_end));
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
        end
    end

    function automatic void add_row(stim_row_t sr);
        plan.insert(plan.size(), sr);
    endfunction

    function automatic stim_row_t reg_row(logic [eapr_pkg::CFG_IDX_W-1:0] idx,
                                          logic [eapr_pkg::CFG_DATA_W-1:0] val);
        stim_row_t sr;
        sr.kind = ROW_REG;
        sr.reg_idx = idx;
        sr.reg_val = val;
        sr.px = '0;
        sr.pinned = 1'b0;
        sr.res = '0;
        return sr;
    endfunction

    function automatic stim_row_t pix_row(logic [eapr_pkg::COLOR_W-1:0] color,
                                          logic [eapr_pkg::ALPHA_W-1:0] alpha,
                                          logic start);
        stim_row_t sr;
        sr.kind = ROW_PIXEL;
        sr.reg_idx = '0;
        sr.reg_val = '0;
        sr.px.pixel_color = color;
        sr.px.pixel_alpha = alpha;
        sr.px.start_image = start;
        sr.pinned = 1'b0;
        sr.res = '0;
        return sr;
    endfunction

    function automatic stim_row_t pix_exp(logic [eapr_pkg::COLOR_W-1:0] color,
                                          logic [eapr_pkg::ALPHA_W-1:0] alpha,
                                          logic start,
                                          logic [eapr_pkg::COLOR_W-1:0] ocolor,
                                          logic [eapr_pkg::ALPHA_W-1:0] oalpha,
                                          logic ocell, logic oend);
        stim_row_t sr;
        sr = pix_row(color, alpha, start);
        sr.pinned = 1'b1;
        sr.res.out_color = ocolor;
        sr.res.out_alpha = oalpha;
        sr.res.cell_value = ocell;
        sr.res.column_end = oend;
        return sr;
    endfunction

    function automatic eapr_pkg::in_item_t rand_pixel(logic start);
        eapr_pkg::in_item_t px;
        px.pixel_color = 24'($urandom_range(0, 24'hFFFFFF));
        case ($urandom_range(5))
            0, 1: px.pixel_alpha = '0;
            2: px.pixel_alpha = $urandom_range(1) ? 8'hFF : 8'h01;
            default: px.pixel_alpha = 8'($urandom_range(0, 255));
        endcase
        px.start_image = start;
        return px;
    endfunction

    task automatic send_pixel(eapr_pkg::in_item_t px, logic pin, eapr_pkg::out_item_t res);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= px;
        pinned_valid <= pin;
        pinned_result <= res;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (results_seen < items_sent)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [eapr_pkg::CFG_IDX_W-1:0] idx,
                             logic [eapr_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic randomize_config();
        logic [eapr_pkg::RULE_BITS-1:0] rule_v;
        logic [eapr_pkg::COLOR_W-1:0] on_v;
        logic [eapr_pkg::COLOR_W-1:0] off_v;
        logic [eapr_pkg::SEED_W-1:0] seed_v;
        logic [eapr_pkg::HEIGHT_W-1:0] height_v;
        case ($urandom_range(7))
            0: rule_v = '0;
            1: rule_v = '1;
            default: rule_v = 8'($urandom_range(0, 255));
        endcase
        on_v = ($urandom_range(7) == 0) ? 24'hFFFFFF
                                         : 24'($urandom_range(0, 24'hFFFFFF));
        off_v = ($urandom_range(7) == 0) ? 24'h000000
                                          : 24'($urandom_range(0, 24'hFFFFFF));
        case ($urandom_range(9))
            0: seed_v = '0;
            1: seed_v = '1;
            default: seed_v = {$urandom, $urandom};
        endcase
        case ($urandom_range(9))
            0: height_v = 7'd1;
            1: height_v = 7'd2;
            2: height_v = 7'd3;
            3: height_v = 7'd64;
            4: height_v = 7'd0;
            5: height_v = 7'($urandom_range(65, 127));
            default: height_v = 7'($urandom_range(1, 16));
        endcase
        wait_idle();
        write_reg(eapr_pkg::REG_RULE_NUMBER, 64'(rule_v));
        write_reg(eapr_pkg::REG_COLOR_ON, 64'(on_v));
        write_reg(eapr_pkg::REG_COLOR_OFF, 64'(off_v));
        write_reg(eapr_pkg::REG_SEED_PATTERN, seed_v);
        write_reg(eapr_pkg::REG_COLUMN_HEIGHT, 64'(height_v));
        cfg_valid <= 1'b0;
        img_rows = rows_for(height_v);
    endtask

    task automatic run_image();
        int unsigned cols;
        int unsigned npix;
        logic fresh;
        fresh = ($urandom_range(9) != 0);
        cols = (img_rows > 32) ? $urandom_range(1, 2) : $urandom_range(1, 4);
        npix = cols * img_rows;
        if ($urandom_range(7) == 0)
        begin
            npix = $urandom_range(1, npix);
        end
        for (int unsigned i = 0; i < npix; i++)
        begin
            send_pixel(rand_pixel((i == 0 && fresh) || $urandom_range(49) == 0), 1'b0, '0);
            random_sent++;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pinned_valid = 1'b0;
        pinned_result = '0;

        add_row(pix_exp(24'h000000, 8'hFF, 1'b1,
                        24'h000000, eapr_pkg::ALPHA_OPAQUE, 1'b0, 1'b0));
        add_row(pix_exp(24'hFFFFFF, 8'h00, 1'b0, 24'hFFFFFF, 8'h00, 1'b0, 1'b0));
        add_row(pix_exp(24'hABCDEF, 8'h01, 1'b0,
                        24'h000000, eapr_pkg::ALPHA_OPAQUE, 1'b0, 1'b0));
        add_row(reg_row(eapr_pkg::REG_RULE_NUMBER, 64'hFF));
        add_row(reg_row(eapr_pkg::REG_COLOR_ON, 64'hFFFFFF));
        add_row(reg_row(eapr_pkg::REG_COLOR_OFF, 64'h000000));
        add_row(reg_row(eapr_pkg::REG_SEED_PATTERN, 64'hFFFF_FFFF_FFFF_FFFF));
        add_row(reg_row(eapr_pkg::REG_COLUMN_HEIGHT, 64'd1));
        add_row(pix_exp(24'h000000, 8'h80, 1'b1,
                        24'hFFFFFF, eapr_pkg::ALPHA_OPAQUE, 1'b1, 1'b1));
        add_row(pix_exp(24'h123456, 8'h00, 1'b0, 24'h123456, 8'h00, 1'b1, 1'b1));
        add_row(reg_row(eapr_pkg::REG_RULE_NUMBER, 64'h00));
        add_row(reg_row(eapr_pkg::REG_COLOR_OFF, 64'h5A5A5A));
        add_row(reg_row(eapr_pkg::REG_COLUMN_HEIGHT, 64'd0));
        add_row(pix_exp(24'hFFFFFF, 8'hFF, 1'b0,
                        24'h5A5A5A, eapr_pkg::ALPHA_OPAQUE, 1'b0, 1'b1));
        add_row(reg_row(eapr_pkg::REG_RULE_NUMBER, 64'd30));
        add_row(reg_row(eapr_pkg::REG_COLOR_ON, 64'h00FF00));
        add_row(reg_row(eapr_pkg::REG_COLOR_OFF, 64'h0000FF));
        add_row(reg_row(eapr_pkg::REG_SEED_PATTERN, 64'h1));
        add_row(reg_row(eapr_pkg::REG_COLUMN_HEIGHT, 64'd2));
        add_row(pix_row(24'h808080, 8'h7F, 1'b1));
        add_row(pix_row(24'h010101, 8'hFE, 1'b0));
        add_row(pix_row(24'h0F0F0F, 8'h00, 1'b0));
        add_row(pix_row(24'hF0F0F0, 8'hFF, 1'b0));
        add_row(reg_row(eapr_pkg::REG_RULE_NUMBER, 64'd150));
        add_row(reg_row(eapr_pkg::REG_SEED_PATTERN, 64'h8000_0000_0000_0001));
        add_row(reg_row(eapr_pkg::REG_COLUMN_HEIGHT, 64'd127));
        add_row(pix_row(24'h555555, 8'h01, 1'b1));
        add_row(pix_row(24'hAAAAAA, 8'h00, 1'b0));
        add_row(pix_row(24'h00FFFF, 8'hFF, 1'b0));
        add_row(pix_row(24'hFF0000, 8'h40, 1'b0));
        add_row(pix_row(24'h000001, 8'h00, 1'b0));
        add_row(pix_row(24'h800000, 8'h02, 1'b0));
        add_row(reg_row(eapr_pkg::REG_COLUMN_HEIGHT, 64'd3));
        add_row(pix_row(24'h112233, 8'hFF, 1'b0));
        add_row(pix_row(24'h445566, 8'hFF, 1'b0));
        add_row(pix_row(24'h778899, 8'h00, 1'b0));
        add_row(pix_row(24'hCCDDEE, 8'h10, 1'b1));
        add_row(reg_row(eapr_pkg::REG_RULE_NUMBER, 64'd110));
        add_row(reg_row(eapr_pkg::REG_SEED_PATTERN, 64'hDEAD_BEEF_0123_4567));
        add_row(reg_row(eapr_pkg::REG_COLUMN_HEIGHT, 64'd64));
        add_row(pix_row(24'h7F7F7F, 8'hFF, 1'b1));
        add_row(pix_row(24'h3C3C3C, 8'h00, 1'b0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[k])
        begin
            if (plan[k].kind == ROW_REG)
            begin
                if (k == 0 || plan[k-1].kind == ROW_PIXEL)
                begin
                    wait_idle();
                end
                write_reg(plan[k].reg_idx, plan[k].reg_val);
                if (k == plan.size() - 1 || plan[k+1].kind == ROW_PIXEL)
                begin
                    cfg_valid <= 1'b0;
                end
            end
            else
            begin
                send_pixel(plan[k].px, plan[k].pinned, plan[k].res);
            end
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            gap_pct = (ph == 0) ? 6 : (ph == 1) ? 65 : 0;
            stall_pct = (ph == 0) ? 65 : (ph == 1) ? 6 : 0;
            while (random_sent < (ph + 1) * RANDOM_ITEMS / 3)
            begin
                randomize_config();
                repeat ($urandom_range(1, 3)) run_image();
            end
        end

        wait_idle();
        if (fail_count == 0 && recolored_q.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
